/* design/irbt_pkg.sv */
package irbt_pkg;

    localparam int CHAN_W = 3;
    localparam int DATA_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        OP_CAL_AMBIENT = 3'd0,
        OP_CAL_MOTOR   = 3'd1,
        OP_CAL_LED     = 3'd2,
        OP_TRACK       = 3'd3,
        OP_SET_BG      = 3'd4,
        OP_QUERY       = 3'd5,
        OP_CLEAR_COUNT = 3'd6,
        OP_SPARE       = 3'd7
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD_MARGIN = 2'd0,
        REG_SETTLE_COUNT     = 2'd1,
        REG_SPARE_2          = 2'd2,
        REG_SPARE_3          = 2'd3
    } reg_index_t;

    localparam logic [DATA_W-1:0] UNSET_VALUE     = 16'hFFFF;
    localparam logic [DATA_W-1:0] MARGIN_RESET    = 16'd4;
    localparam logic [DATA_W-1:0] SETTLE_RESET    = 16'd8000;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [CHAN_W-1:0]        channel;
        logic [DATA_W-1:0]        sample;
        logic signed [DATA_W-1:0] diff;
        logic                     moving;
        logic [8:0]               led_mask;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] threshold;
        logic [DATA_W-1:0] background;
        logic              settled;
        logic [DATA_W-1:0] sample_count;
    } result_t;

    typedef struct packed {
        reg_index_t        index;
        logic [DATA_W-1:0] value;
    } cfg_t;

    // one table row per channel
    typedef struct packed {
        logic [DATA_W-1:0] baseline;
        logic [DATA_W-1:0] motor_offset;
        logic [DATA_W-1:0] led_offset;
    } entry_t;

    // memory control between sequencer and store
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [CHAN_W-1:0] chan;
    } store_ctl_t;

    // leds adjacent to each channel, bit 8 is the front led
    function automatic logic [8:0] led_near(input logic [CHAN_W-1:0] ch);
        logic [8:0] m;
        begin
            case (ch)
                3'd0:    m = 9'h103;
                3'd1:    m = 9'h102;
                3'd2:    m = 9'h00E;
                3'd3:    m = 9'h018;
                3'd4:    m = 9'h030;
                3'd5:    m = 9'h0E0;
                3'd6:    m = 9'h0C0;
                default: m = 9'h181;
            endcase
            return m;
        end
    endfunction

    function automatic entry_t entry_reset(input logic [CHAN_W-1:0] ch);
        entry_t e;
        begin
            if (ch == '0)
            begin
                e.baseline     = UNSET_VALUE;
                e.motor_offset = UNSET_VALUE;
                e.led_offset   = UNSET_VALUE;
            end
            else
            begin
                e = '0;
            end
            return e;
        end
    endfunction

    function automatic logic is_unset(input logic [DATA_W-1:0] v);
        return (v == '0) || (v == UNSET_VALUE);
    endfunction

    // one signed step of an offset toward its target
    function automatic logic [DATA_W-1:0] step_signed(input logic [DATA_W-1:0] cur,
                                                      input logic [DATA_W-1:0] target);
        logic [DATA_W-1:0] r;
        begin
            if ($signed(target) > $signed(cur))
                r = cur + 16'd1;
            else if ($signed(target) < $signed(cur))
                r = cur - 16'd1;
            else
                r = cur;
            return r;
        end
    endfunction

endpackage

/* design/irbt_stream_if.sv */
interface irbt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/irbt_store.sv */
module irbt_store #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  irbt_pkg::store_ctl_t ctl,
    input  irbt_pkg::entry_t    wr_data,
    output irbt_pkg::entry_t    rd_data
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    irbt_pkg::entry_t                  mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]           valid_reg;
    irbt_pkg::entry_t                  rd_data_reg;
    logic                              rd_valid_reg;
    logic [irbt_pkg::CHAN_W-1:0]       rd_chan_reg;
    logic [IDX_W-1:0]                  idx;

    assign idx = ctl.chan[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[idx] <= wr_data;
        if (ctl.rd_en)
            rd_data_reg <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_chan_reg  <= '0;
        end
        else
        begin
            if (ctl.wr_en)
                valid_reg[idx] <= 1'b1;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[idx];
                rd_chan_reg  <= ctl.chan;
            end
        end
    end

    // never written entries read as their reset value
    assign rd_data = rd_valid_reg ? rd_data_reg : irbt_pkg::entry_reset(rd_chan_reg);

endmodule

/* design/irbt_update.sv */
module irbt_update (
    input  irbt_pkg::item_t   item,
    input  irbt_pkg::entry_t  cur,
    input  logic              in_range,
    input  logic [15:0]       counter,
    input  logic [15:0]       margin,
    input  logic [15:0]       settle,
    output irbt_pkg::entry_t  nxt,
    output logic [15:0]       counter_nxt,
    output irbt_pkg::result_t result
);

    logic        near;
    logic [15:0] act_old;
    logic [15:0] act_new;
    logic [15:0] target;
    logic signed [16:0] track_sum;
    logic [15:0] bg;

    assign near   = |(item.led_mask & irbt_pkg::led_near(item.channel));
    assign target = cur.baseline - item.sample;

    assign act_old = (item.moving ? cur.motor_offset : 16'd0)
                   + (near ? cur.led_offset : 16'd0);
    assign track_sum = 17'($signed(item.diff)) + 17'($signed(act_old));

    always_comb
    begin
        nxt         = cur;
        counter_nxt = counter;
        if (in_range)
        begin
            case (item.opcode)
                irbt_pkg::OP_CAL_AMBIENT:
                begin
                    if (irbt_pkg::is_unset(cur.baseline))
                        nxt.baseline = item.sample;
                    else
                    begin
                        if (cur.baseline > item.sample)
                            nxt.baseline = cur.baseline - 16'd1;
                        else if (cur.baseline < item.sample)
                            nxt.baseline = cur.baseline + 16'd1;
                        counter_nxt = counter + 16'd1;
                    end
                end
                irbt_pkg::OP_CAL_MOTOR:
                begin
                    if (irbt_pkg::is_unset(cur.motor_offset))
                        nxt.motor_offset = target;
                    else
                        nxt.motor_offset = irbt_pkg::step_signed(cur.motor_offset, target);
                end
                irbt_pkg::OP_CAL_LED:
                begin
                    if (irbt_pkg::is_unset(cur.led_offset))
                        nxt.led_offset = target;
                    else
                    begin
                        nxt.led_offset = irbt_pkg::step_signed(cur.led_offset, target);
                        counter_nxt    = counter + 16'd1;
                    end
                end
                irbt_pkg::OP_TRACK:
                begin
                    if (track_sum > 17'sd0)
                        nxt.baseline = cur.baseline + 16'd1;
                    else if (track_sum < 17'sd0)
                        nxt.baseline = cur.baseline - 16'd1;
                end
                irbt_pkg::OP_SET_BG:
                    nxt.baseline = item.sample;
                irbt_pkg::OP_CLEAR_COUNT:
                    counter_nxt = '0;
                default:
                    ;
            endcase
        end
    end

    // offsets as they stand after the update
    assign act_new = (item.moving ? nxt.motor_offset : 16'd0)
                   + (near ? nxt.led_offset : 16'd0);
    assign bg      = nxt.baseline - act_new;

    assign result.background   = in_range ? bg : 16'd0;
    assign result.threshold    = in_range ? (bg - margin) : 16'd0;
    assign result.settled      = (counter_nxt >= settle);
    assign result.sample_count = counter_nxt;

endmodule

/* design/ir_channel_baseline_tracker.sv */
// infrared channel baseline tracker
//
// item:   sink channel; each transfer carries opcode, channel, sample, diff,
//         moving and led_mask. one result transfer follows every item.
// result: source channel with threshold, background, settled and
//         sample_count, all taken after the item's update.
// cfg:    register write channel, always ready; index 0 is threshold_margin,
//         index 1 is settle_count, other indexes are ignored. write only
//         while no item is in flight.
// order:  the item transfer registers the item and its table read; the calc
//         state updates, writes back and fills a free output register.
// items:  a new item is taken only in the idle state, after the last one's
//         update and write back to the single-ported per-channel table.
// reset: asynchronous, clears the sequencer, the output register and the
//         entry valid bits; entry 0 reads as the unset pattern, others as 0.
// stall: while a result waits, the next item is still accepted and read; its
//         update waits in the calc state until the output register frees up.
module ir_channel_baseline_tracker #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    irbt_stream_if.sink         item,
    irbt_stream_if.source       result,
    irbt_stream_if.sink         cfg
);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t              state_reg;
    irbt_pkg::item_t     item_reg;
    irbt_pkg::result_t   result_reg;
    logic                out_valid_reg;
    logic [15:0]         counter_reg;
    logic [15:0]         margin_reg;
    logic [15:0]         settle_reg;

    irbt_pkg::store_ctl_t store_ctl;
    irbt_pkg::entry_t    rd_entry;
    irbt_pkg::entry_t    wr_entry;
    irbt_pkg::result_t   result_next;
    logic [15:0]         counter_next;

    logic item_xfer;
    logic out_free;
    logic commit;
    logic in_range;

    // input is taken only between items; the table read starts at once
    assign item.ready = (state_reg == S_IDLE);
    assign item_xfer  = item.valid && item.ready;

    assign out_free = !out_valid_reg || result.ready;
    assign commit   = (state_reg == S_CALC) && out_free;

    // channels past the table leave state alone
    assign in_range = {1'b0, item_reg.channel} < 4'(NUM_CHANNELS);

    assign cfg.ready = 1'b1;

    always_comb
    begin
        store_ctl.rd_en = item_xfer;
        store_ctl.wr_en = commit && in_range;
        store_ctl.chan  = item_xfer ? item.data.channel : item_reg.channel;
    end

    irbt_store #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (store_ctl),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    irbt_update u_update (
        .item        (item_reg),
        .cur         (rd_entry),
        .in_range    (in_range),
        .counter     (counter_reg),
        .margin      (margin_reg),
        .settle      (settle_reg),
        .nxt         (wr_entry),
        .counter_nxt (counter_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            counter_reg   <= '0;
            margin_reg    <= irbt_pkg::MARGIN_RESET;
            settle_reg    <= irbt_pkg::SETTLE_RESET;
        end
        else
        begin
            // register writes
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.data.index)
                    irbt_pkg::REG_THRESHOLD_MARGIN: margin_reg <= cfg.data.value;
                    irbt_pkg::REG_SETTLE_COUNT:     settle_reg <= cfg.data.value;
                    default:                        ;
                endcase
            end

            // a new result replaces the one leaving in the same cycle
            if (commit)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_xfer)
                    begin
                        item_reg  <= item.data;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    // hold here until the previous result has been taken
                    if (commit)
                    begin
                        result_reg    <= result_next;
                        counter_reg   <= counter_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

endmodule
